// ===== rtl/cht_pkg.sv =====
// Shared types, field widths and codes for the chained hash table.
package cht_pkg;

    localparam int KEY_W = 16;
    localparam int QTY_W = 16;
    localparam int REQ_W = 2;
    localparam int ST_W  = 2;

    localparam int BUCKETS_DEF = 16;
    localparam int WAYS_DEF    = 4;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [KEY_W-1:0] key;
        logic [QTY_W-1:0] quantity_in;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [QTY_W-1:0] quantity_out;
    } rsp_t;

endpackage

// ===== rtl/cht_index.sv =====
// Pipelined key modulo BUCKETS unit built on a reciprocal multiply.
module cht_index #(
    parameter int BUCKETS = cht_pkg::BUCKETS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [cht_pkg::KEY_W-1:0]    key,
    output logic                         out_valid,
    output logic [$clog2(BUCKETS)-1:0]   bucket
);
    import cht_pkg::*;

    localparam int BIDX_W = $clog2(BUCKETS);
    localparam int REM_W  = KEY_W + 1;
    localparam logic [63:0] RECIP64 = 64'h1_0000_0000 / 64'(BUCKETS);
    localparam logic [31:0] RECIP   = RECIP64[31:0];
    localparam logic [REM_W-1:0] BUCKETS_R = REM_W'(BUCKETS);

    logic                  v1_reg, v2_reg, v3_reg;
    logic [KEY_W-1:0]      key1_reg, key2_reg;
    logic [KEY_W+31:0]     prod_reg;
    logic [REM_W-1:0]      qb_reg;
    logic [BIDX_W-1:0]     bucket_reg;
    logic [KEY_W-1:0]      q_est;
    logic [KEY_W+REM_W-1:0] qb_full;
    logic [REM_W-1:0]      rem_raw;
    logic [REM_W-1:0]      rem_fix;

    // The estimated quotient is low by at most one, so one subtract corrects it.
    always_comb
    begin
        q_est   = prod_reg[KEY_W+31:32];
        qb_full = q_est * BUCKETS_R;
        rem_raw = {1'b0, key2_reg} - qb_reg;
        rem_fix = (rem_raw >= BUCKETS_R) ? (rem_raw - BUCKETS_R) : rem_raw;
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Datapath: multiply by reciprocal, multiply back, subtract and correct.
    always_ff @(posedge clk)
    begin
        key1_reg   <= key;
        prod_reg   <= key * RECIP;
        key2_reg   <= key1_reg;
        qb_reg     <= qb_full[REM_W-1:0];
        bucket_reg <= rem_fix[BIDX_W-1:0];
    end

    assign out_valid = v3_reg;
    assign bucket    = bucket_reg;

endmodule

// ===== rtl/cht_ram.sv =====
// Bucket row memory with one write port and one registered read port.
module cht_ram #(
    parameter int DEPTH = cht_pkg::BUCKETS_DEF,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);
    import cht_pkg::*;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, loaded while rd_en is high.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/chained_hash_table.sv =====
// Top level of the chained hash table: request control, bucket update and results.
//
// A request transfers when start is high and busy is low. Its bucket is key modulo
// BUCKETS, found in a three-stage reciprocal multiply unit; the bucket's row (fill
// count, keys and quantities of all WAYS entries) is then read from one memory,
// compared across all ways at once, and the shifted row is written back in the same
// cycle that the result is registered. Each request passes from transfer to result
// through the index unit, then the memory read, then the update. The result is
// shown for one cycle with done high and must be taken then; busy is low in that
// cycle, so the next request can transfer together with it. After reset the block
// runs a clearing pass that writes a zero row to every bucket, with busy high,
// before it takes the first request.
module chained_hash_table #(
    parameter int BUCKETS = cht_pkg::BUCKETS_DEF,
    parameter int WAYS    = cht_pkg::WAYS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  cht_pkg::req_t req,
    output logic          done,
    output cht_pkg::rsp_t rsp
);
    import cht_pkg::*;

    localparam int BIDX_W = $clog2(BUCKETS);
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W  = FILL_W + WAYS * (KEY_W + QTY_W);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WAYS);
    localparam logic [BIDX_W-1:0] LAST_BKT = BIDX_W'(BUCKETS - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_INDEX, S_UPDATE} state_t;

    state_t               state_reg;
    logic [BIDX_W-1:0]    clr_reg;
    logic [BIDX_W-1:0]    bucket_reg;
    req_t                 req_reg;
    logic                 done_reg;
    rsp_t                 rsp_reg;

    logic                 accept;
    logic                 idx_valid;
    logic [BIDX_W-1:0]    idx_bucket;
    logic [ROW_W-1:0]     rd_data;
    logic                 wr_en;
    logic [BIDX_W-1:0]    wr_addr;
    logic [ROW_W-1:0]     wr_data;

    logic [FILL_W-1:0]                old_fill;
    logic [WAYS-1:0][KEY_W-1:0]       old_keys;
    logic [WAYS-1:0][QTY_W-1:0]       old_qty;
    logic [WAYS-1:0][KEY_W-1:0]       new_keys;
    logic [WAYS-1:0][QTY_W-1:0]       new_qty;
    logic [FILL_W-1:0]                new_fill;
    logic [WAYS-1:0]                  hit;
    logic                             found;
    logic [WAY_W-1:0]                 hit_way;
    logic                             upd_write;
    rsp_t                             upd_rsp;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    cht_index #(
        .BUCKETS (BUCKETS)
    ) u_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .key       (req.key),
        .out_valid (idx_valid),
        .bucket    (idx_bucket)
    );

    cht_ram #(
        .DEPTH (BUCKETS),
        .WIDTH (ROW_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (idx_valid),
        .rd_addr (idx_bucket),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Unpack the bucket row and find the newest matching live entry.
    always_comb
    begin
        old_fill = rd_data[ROW_W-1 -: FILL_W];
        old_qty  = rd_data[WAYS*(KEY_W+QTY_W)-1 : WAYS*KEY_W];
        old_keys = rd_data[WAYS*KEY_W-1 : 0];
        found    = 1'b0;
        hit_way  = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            hit[w] = (FILL_W'(w) < old_fill) && (old_keys[w] == req_reg.key);
        end
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (hit[w])
            begin
                found   = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    // Build the new row and the result for the request in hand.
    always_comb
    begin
        new_keys  = old_keys;
        new_qty   = old_qty;
        new_fill  = old_fill;
        upd_write = 1'b0;
        upd_rsp   = '{status: ST_NOT_FOUND, quantity_out: '0};
        unique case (req_reg.req_type)
            REQ_INSERT:
            begin
                if (old_fill >= FILL_MAX)
                begin
                    upd_rsp.status = ST_FULL;
                end
                else
                begin
                    new_keys[0] = req_reg.key;
                    new_qty[0]  = req_reg.quantity_in;
                    for (int i = 1; i < WAYS; i++)
                    begin
                        new_keys[i] = old_keys[i-1];
                        new_qty[i]  = old_qty[i-1];
                    end
                    new_fill       = old_fill + 1'b1;
                    upd_write      = 1'b1;
                    upd_rsp.status = ST_OK;
                end
            end
            REQ_SEARCH:
            begin
                if (found)
                begin
                    upd_rsp.status       = ST_OK;
                    upd_rsp.quantity_out = old_qty[hit_way];
                end
            end
            REQ_DELETE:
            begin
                if (found)
                begin
                    for (int i = 0; i < WAYS - 1; i++)
                    begin
                        if (WAY_W'(i) >= hit_way)
                        begin
                            new_keys[i] = old_keys[i+1];
                            new_qty[i]  = old_qty[i+1];
                        end
                    end
                    new_fill       = old_fill - 1'b1;
                    upd_write      = 1'b1;
                    upd_rsp.status = ST_OK;
                end
            end
            default:
            begin
                upd_rsp.status = ST_NOT_FOUND;
            end
        endcase
    end

    // Memory write: zero rows during the clearing pass, updated rows afterwards.
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = (state_reg == S_UPDATE) && upd_write;
            wr_addr = bucket_reg;
            wr_data = {new_fill, new_qty, new_keys};
        end
    end

    // Request sequencer with registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            bucket_reg <= '0;
            req_reg    <= '0;
            done_reg   <= 1'b0;
            rsp_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == LAST_BKT)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg   <= req;
                        state_reg <= S_INDEX;
                    end
                end
                S_INDEX:
                begin
                    if (idx_valid)
                    begin
                        bucket_reg <= idx_bucket;
                        state_reg  <= S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    rsp_reg   <= upd_rsp;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // A transfer always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("block not busy after a request transfer");

    // Only an insert can report a full bucket.
    a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp_reg.status == ST_FULL) |-> req_reg.req_type == REQ_INSERT)
        else $error("full status on a request other than insert");

    // A nonzero quantity comes only from a successful search.
    a_qty_search: assert property (@(posedge clk) disable iff (!rst_n)
        done && (rsp_reg.quantity_out != '0)
            |-> (req_reg.req_type == REQ_SEARCH) && (rsp_reg.status == ST_OK))
        else $error("quantity returned on a request that is not a found search");

    // The index unit delivers a bucket only while the sequencer waits for it.
    a_idx_wait: assert property (@(posedge clk) disable iff (!rst_n)
        idx_valid |-> state_reg == S_INDEX)
        else $error("bucket index delivered outside the index wait");

endmodule
